[rtl/ipdt_pkg.sv]
// ----------------------------------------------------------------------------
// ipdt_pkg
// Shared types, constants and phase helpers of the pulse-distance IR sender.
// ----------------------------------------------------------------------------
package ipdt_pkg;

  localparam logic [5:0]  CARRIER_HALF  = 6'd26;
  localparam logic [15:0] TRAILER_GAP2  = 16'd2532;
  localparam logic [15:0] TRAILER_MARK2 = 16'd676;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER_MARK  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SPACE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER_EN   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER_GAP  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER_MARK = 4'd7;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_BIT   = 2'd2;
  localparam logic [1:0] FUNC_END   = 2'd3;

  // Bound on the walk past zero-length phases; covers the longest chain plus one.
  localparam int unsigned SKIP_STEPS = 8;

  typedef struct packed {
    logic [1:0] func;
    logic       bit_value;
  } in_item_t;

  typedef struct packed {
    logic ir_level;
    logic ready_res;
    logic accepted;
  } out_item_t;

  typedef struct packed {
    logic [15:0] header_mark_us;
    logic [15:0] header_space_us;
    logic [15:0] bit_mark_us;
    logic [15:0] zero_space_us;
    logic [15:0] one_space_us;
    logic        trailer_enable;
    logic [15:0] trailer_gap_us;
    logic [15:0] trailer_mark_us;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_BIT0  = 3'd2,
    OP_BIT1  = 3'd3,
    OP_END   = 3'd4
  } op_e;

  typedef enum logic [9:0] {
    PH_IDLE      = 10'b00_0000_0001,
    PH_HDR_MARK  = 10'b00_0000_0010,
    PH_HDR_SPACE = 10'b00_0000_0100,
    PH_BIT_MARK  = 10'b00_0000_1000,
    PH_WAIT      = 10'b00_0001_0000,
    PH_BIT_SPACE = 10'b00_0010_0000,
    PH_TR_GAP    = 10'b00_0100_0000,
    PH_TR_MARK   = 10'b00_1000_0000,
    PH_TR_GAP2   = 10'b01_0000_0000,
    PH_TR_MARK2  = 10'b10_0000_0000
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] ticks;
    logic        pending;
  } enter_t;

  function automatic logic is_mark(phase_e p);
    return (p == PH_HDR_MARK) || (p == PH_BIT_MARK) ||
           (p == PH_TR_MARK) || (p == PH_TR_MARK2);
  endfunction

  function automatic logic [15:0] length_of(phase_e p, cfg_t cfg);
    logic [15:0] l;
    unique case (p)
      PH_HDR_MARK:  l = cfg.header_mark_us;
      PH_HDR_SPACE: l = cfg.header_space_us;
      PH_BIT_MARK:  l = cfg.bit_mark_us;
      PH_TR_GAP:    l = cfg.trailer_gap_us;
      PH_TR_MARK:   l = cfg.trailer_mark_us;
      PH_TR_GAP2:   l = TRAILER_GAP2;
      PH_TR_MARK2:  l = TRAILER_MARK2;
      default:      l = 16'd0;
    endcase
    return l;
  endfunction

  // Enter phase p with length len, walking past phases of zero length.
  function automatic enter_t enter_phase(phase_e p, logic [15:0] len, logic pend, cfg_t cfg);
    enter_t      r;
    phase_e      cur;
    logic [15:0] l;
    logic        pnd;
    logic        done;
    cur  = p;
    l    = len;
    pnd  = pend;
    done = 1'b0;
    for (int i = 0; i < SKIP_STEPS; i++) begin
      if (!done) begin
        if ((cur == PH_IDLE) || (cur == PH_WAIT) || (l != 16'd0)) begin
          done = 1'b1;
        end else begin
          unique case (cur)
            PH_HDR_MARK:  cur = PH_HDR_SPACE;
            PH_HDR_SPACE: cur = PH_BIT_MARK;
            PH_BIT_MARK: begin
              if (pnd) begin
                pnd = 1'b0;
                cur = cfg.trailer_enable ? PH_TR_GAP : PH_IDLE;
              end else begin
                cur = PH_WAIT;
              end
            end
            PH_BIT_SPACE: cur = PH_BIT_MARK;
            PH_TR_GAP:    cur = PH_TR_MARK;
            PH_TR_MARK:   cur = PH_TR_GAP2;
            PH_TR_GAP2:   cur = PH_TR_MARK2;
            default:      cur = PH_IDLE;
          endcase
          l = length_of(cur, cfg);
        end
      end
    end
    r.phase   = cur;
    r.ticks   = l;
    r.pending = pnd;
    return r;
  endfunction

endpackage

[rtl/ir_pulse_distance_transmitter_top.sv]
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter_top
// Pulse-distance IR frame sender with a toggling carrier during marks.
//
//   channel | dir | handshake             | word
//   in      | in  | in_valid_i/in_ready_o | in_item_t  (func, bit_value)
//   out     | out | out_valid_o/out_ready_i | out_item_t (ir_level, ready_res, accepted)
//   cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One word per cycle while the output is not stalled; each phase engine step handles one word.
// From input accept to result valid, a word passes the input stage
// register, then a queue entry, and the engine step loads the output register.
// Reset puts the engine idle and loads the default timings; no init sweep.
// An output stall fills the queue, then backs up to in_ready_o.
// Config writes are always taken.
// ----------------------------------------------------------------------------
module ir_pulse_distance_transmitter_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  ipdt_pkg::in_item_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output ipdt_pkg::out_item_t              out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ipdt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ipdt_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  ipdt_pkg::cfg_t cfg;
  logic           push_valid, push_ready;
  ipdt_pkg::op_e  push_op;
  logic           pop_valid, pop_ready;
  ipdt_pkg::op_e  pop_op;

  assign cfg_ready_o = 1'b1;

  ipdt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_valid_i && cfg_ready_o),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  ipdt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_op_o    (push_op)
  );

  ipdt_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_op_i    (push_op),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_op_o     (pop_op)
  );

  ipdt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_op_i    (pop_op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/ipdt_cfg.sv]
// ----------------------------------------------------------------------------
// ipdt_cfg
// Timing register file, written one word at a time from the config port.
// ----------------------------------------------------------------------------
module ipdt_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [ipdt_pkg::CFG_IDX_W-1:0]   index_i,
  input  logic [ipdt_pkg::CFG_DATA_W-1:0]  data_i,
  output ipdt_pkg::cfg_t                   cfg_o
);

  ipdt_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (index_i)
        ipdt_pkg::REG_HEADER_MARK:  cfg_d.header_mark_us  = data_i;
        ipdt_pkg::REG_HEADER_SPACE: cfg_d.header_space_us = data_i;
        ipdt_pkg::REG_BIT_MARK:     cfg_d.bit_mark_us     = data_i;
        ipdt_pkg::REG_ZERO_SPACE:   cfg_d.zero_space_us   = data_i;
        ipdt_pkg::REG_ONE_SPACE:    cfg_d.one_space_us    = data_i;
        ipdt_pkg::REG_TRAILER_EN:   cfg_d.trailer_enable  = data_i[0];
        ipdt_pkg::REG_TRAILER_GAP:  cfg_d.trailer_gap_us  = data_i;
        ipdt_pkg::REG_TRAILER_MARK: cfg_d.trailer_mark_us = data_i;
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_mark_us  <= 16'd3400;
      cfg_q.header_space_us <= 16'd1700;
      cfg_q.bit_mark_us     <= 16'd450;
      cfg_q.zero_space_us   <= 16'd500;
      cfg_q.one_space_us    <= 16'd1200;
      cfg_q.trailer_enable  <= 1'b0;
      cfg_q.trailer_gap_us  <= 16'd45356;
      cfg_q.trailer_mark_us <= 16'd10240;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/ipdt_front.sv]
// ----------------------------------------------------------------------------
// ipdt_front
// Input stage: takes a word, decodes it into an operation, hands it on.
// ----------------------------------------------------------------------------
module ipdt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ipdt_pkg::in_item_t in_data_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output ipdt_pkg::op_e      push_op_o
);

  logic          valid_q, valid_d;
  ipdt_pkg::op_e op_q, op_d;
  logic          take;

  assign in_ready_o = !valid_q || push_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    unique case (in_data_i.func)
      ipdt_pkg::FUNC_TICK:  op_d = ipdt_pkg::OP_TICK;
      ipdt_pkg::FUNC_START: op_d = ipdt_pkg::OP_START;
      ipdt_pkg::FUNC_BIT:   op_d = in_data_i.bit_value ? ipdt_pkg::OP_BIT1 : ipdt_pkg::OP_BIT0;
      ipdt_pkg::FUNC_END:   op_d = ipdt_pkg::OP_END;
      default:              op_d = ipdt_pkg::OP_TICK;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q <= op_d;
    end
  end

  assign push_valid_o = valid_q;
  assign push_op_o    = op_q;

endmodule

[rtl/ipdt_fifo.sv]
// ----------------------------------------------------------------------------
// ipdt_fifo
// Two-entry operation queue between the input stage and the phase engine.
// ----------------------------------------------------------------------------
module ipdt_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  ipdt_pkg::op_e push_op_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output ipdt_pkg::op_e pop_op_o
);

  ipdt_pkg::op_e mem_q [2];
  logic          wptr_q, wptr_d;
  logic          rptr_q, rptr_d;
  logic [1:0]    count_q, count_d;
  logic          push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_op_o     = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q ^ push;
    rptr_d  = rptr_q ^ pop;
    count_d = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_op_i;
    end
  end

endmodule

[rtl/ipdt_back.sv]
// ----------------------------------------------------------------------------
// ipdt_back
// Phase engine: runs the frame timer and carrier, registers one result word
// for every operation it takes.
// ----------------------------------------------------------------------------
module ipdt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ipdt_pkg::cfg_t      cfg_i,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  ipdt_pkg::op_e       pop_op_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ipdt_pkg::out_item_t out_data_o
);

  ipdt_pkg::phase_e    phase_q, phase_d;
  logic [15:0]         ticks_q, ticks_d;
  logic                pend_q, pend_d;
  logic [5:0]          ccount_q, ccount_d;
  logic                clevel_q, clevel_d;
  logic                out_valid_q, out_valid_d;
  ipdt_pkg::out_item_t out_q, res;
  ipdt_pkg::enter_t    ent;
  logic                do_enter;
  logic                acc;
  logic                step;
  logic [5:0]          cnt_inc;

  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign step        = pop_valid_i && pop_ready_o;
  assign cnt_inc     = ccount_q + 6'd1;

  always_comb begin
    phase_d  = phase_q;
    ticks_d  = ticks_q;
    pend_d   = pend_q;
    ccount_d = ccount_q;
    clevel_d = clevel_q;
    do_enter = 1'b0;
    acc      = 1'b0;
    ent      = '{phase: phase_q, ticks: ticks_q, pending: pend_q};

    unique case (pop_op_i)
      ipdt_pkg::OP_TICK: begin
        if ((phase_q != ipdt_pkg::PH_IDLE) && (phase_q != ipdt_pkg::PH_WAIT) &&
            (ticks_q != 16'd0)) begin
          if (ipdt_pkg::is_mark(phase_q)) begin
            if (cnt_inc >= ipdt_pkg::CARRIER_HALF) begin
              ccount_d = 6'd0;
              clevel_d = !clevel_q;
            end else begin
              ccount_d = cnt_inc;
            end
          end
          ticks_d = ticks_q - 16'd1;
          if (ticks_q == 16'd1) begin
            // timer ran out: walk to the next phase of nonzero length, or to idle or wait
            ent      = ipdt_pkg::enter_phase(phase_q, 16'd0, pend_q, cfg_i);
            do_enter = 1'b1;
          end
        end
      end
      ipdt_pkg::OP_START: begin
        if (phase_q == ipdt_pkg::PH_IDLE) begin
          ent      = ipdt_pkg::enter_phase(ipdt_pkg::PH_HDR_MARK, cfg_i.header_mark_us,
                                           1'b0, cfg_i);
          do_enter = 1'b1;
          acc      = 1'b1;
        end
      end
      ipdt_pkg::OP_BIT0, ipdt_pkg::OP_BIT1: begin
        if (phase_q == ipdt_pkg::PH_WAIT) begin
          ent      = ipdt_pkg::enter_phase(ipdt_pkg::PH_BIT_SPACE,
                                           (pop_op_i == ipdt_pkg::OP_BIT1) ?
                                           cfg_i.one_space_us : cfg_i.zero_space_us,
                                           pend_q, cfg_i);
          do_enter = 1'b1;
          acc      = 1'b1;
        end
      end
      ipdt_pkg::OP_END: begin
        if (phase_q == ipdt_pkg::PH_WAIT) begin
          // same as a bit mark ending with the end held
          ent      = ipdt_pkg::enter_phase(ipdt_pkg::PH_BIT_MARK, 16'd0, 1'b1, cfg_i);
          do_enter = 1'b1;
          acc      = 1'b1;
        end else if (((phase_q == ipdt_pkg::PH_HDR_MARK) ||
                      (phase_q == ipdt_pkg::PH_HDR_SPACE) ||
                      (phase_q == ipdt_pkg::PH_BIT_MARK) ||
                      (phase_q == ipdt_pkg::PH_BIT_SPACE)) && !pend_q) begin
          pend_d = 1'b1;
          acc    = 1'b1;
        end
      end
      default: ;
    endcase

    if (do_enter) begin
      phase_d  = ent.phase;
      ticks_d  = ent.ticks;
      pend_d   = ent.pending;
      ccount_d = 6'd0;
      clevel_d = ipdt_pkg::is_mark(ent.phase);
    end

    res.ir_level  = ipdt_pkg::is_mark(phase_d) && clevel_d;
    res.ready_res = (phase_d == ipdt_pkg::PH_IDLE) || (phase_d == ipdt_pkg::PH_WAIT);
    res.accepted  = acc;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ipdt_pkg::PH_IDLE;
      ticks_q     <= 16'd0;
      pend_q      <= 1'b0;
      ccount_q    <= 6'd0;
      clevel_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (step) begin
        phase_q  <= phase_d;
        ticks_q  <= ticks_d;
        pend_q   <= pend_d;
        ccount_q <= ccount_d;
        clevel_q <= clevel_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pulse-distance IR frame sender.
// A stimulus process queues start, bit, end and tick words. A clocked driver
// feeds them to the block, and a behavioral copy of the phase engine predicts
// each result word at acceptance. A clocked monitor compares every result
// word with the oldest prediction. Timing registers are rewritten between
// traffic phases, and the phases rotate through four idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ipdt_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned REPORT_MAX    = 10;
  localparam int unsigned WORDS_PER_SET = 40;

  // indexes past the register map; writes to them must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 4'd15;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  ir_pulse_distance_transmitter_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Predicted transmitter state and timing registers
  cfg_t        tx_cfg;
  phase_e      tx_phase;
  logic [15:0] tx_left;
  logic        tx_end_held;
  logic [5:0]  tx_carr_cnt;
  logic        tx_carr_lvl;

  in_item_t    tx_word_q[$];
  out_item_t   tx_result_q[$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned words_queued    = 0;
  int unsigned results_seen    = 0;
  int unsigned tx_mismatches   = 0;
  int unsigned cycle_count     = 0;

  function automatic logic tx_burst(phase_e p);
    return p inside {PH_HDR_MARK, PH_BIT_MARK, PH_TR_MARK, PH_TR_MARK2};
  endfunction

  function automatic logic [15:0] tx_len(phase_e p);
    case (p)
      PH_HDR_MARK:  return tx_cfg.header_mark_us;
      PH_HDR_SPACE: return tx_cfg.header_space_us;
      PH_BIT_MARK:  return tx_cfg.bit_mark_us;
      PH_TR_GAP:    return tx_cfg.trailer_gap_us;
      PH_TR_MARK:   return tx_cfg.trailer_mark_us;
      PH_TR_GAP2:   return TRAILER_GAP2;
      PH_TR_MARK2:  return TRAILER_MARK2;
      default:      return 16'd0;
    endcase
  endfunction

  // trailer_enable is sampled only here, when the frame closes
  function automatic phase_e tx_close_frame();
    tx_end_held = 1'b0;
    if (tx_cfg.trailer_enable) return PH_TR_GAP;
    return PH_IDLE;
  endfunction

  function automatic phase_e tx_follow(phase_e p);
    case (p)
      PH_HDR_MARK:  return PH_HDR_SPACE;
      PH_HDR_SPACE: return PH_BIT_MARK;
      PH_BIT_MARK: begin
        if (tx_end_held) return tx_close_frame();
        return PH_WAIT;
      end
      PH_BIT_SPACE: return PH_BIT_MARK;
      PH_TR_GAP:    return PH_TR_MARK;
      PH_TR_MARK:   return PH_TR_GAP2;
      PH_TR_GAP2:   return PH_TR_MARK2;
      default:      return PH_IDLE;
    endcase
  endfunction

  // zero-length phases fall straight through to their successor
  function automatic void tx_enter(phase_e p, logic [15:0] len);
    phase_e      nxt;
    logic [15:0] l;
    nxt = p;
    l   = len;
    for (int i = 0; i < 16; i++) begin
      tx_phase    = nxt;
      tx_left     = l;
      tx_carr_cnt = '0;
      tx_carr_lvl = tx_burst(nxt);
      if (nxt == PH_IDLE || nxt == PH_WAIT || l != 16'd0) return;
      nxt = tx_follow(nxt);
      l   = tx_len(nxt);
    end
  endfunction

  function automatic out_item_t tx_step(in_item_t w);
    out_item_t r;
    phase_e    nxt;
    r = '0;
    case (w.func)
      FUNC_TICK: begin
        if (tx_phase != PH_IDLE && tx_phase != PH_WAIT && tx_left != 16'd0) begin
          if (tx_burst(tx_phase)) begin
            tx_carr_cnt = tx_carr_cnt + 6'd1;
            if (tx_carr_cnt >= CARRIER_HALF) begin
              tx_carr_cnt = '0;
              tx_carr_lvl = ~tx_carr_lvl;
            end
          end
          tx_left = tx_left - 16'd1;
          if (tx_left == 16'd0) begin
            nxt = tx_follow(tx_phase);
            tx_enter(nxt, tx_len(nxt));
          end
        end
      end
      FUNC_START: begin
        if (tx_phase == PH_IDLE) begin
          tx_end_held = 1'b0;
          tx_enter(PH_HDR_MARK, tx_cfg.header_mark_us);
          r.accepted = 1'b1;
        end
      end
      FUNC_BIT: begin
        if (tx_phase == PH_WAIT) begin
          tx_enter(PH_BIT_SPACE, w.bit_value ? tx_cfg.one_space_us : tx_cfg.zero_space_us);
          r.accepted = 1'b1;
        end
      end
      FUNC_END: begin
        if (tx_phase == PH_WAIT) begin
          nxt = tx_close_frame();
          tx_enter(nxt, tx_len(nxt));
          r.accepted = 1'b1;
        end else if (!tx_end_held &&
                     tx_phase inside {PH_HDR_MARK, PH_HDR_SPACE, PH_BIT_MARK, PH_BIT_SPACE}) begin
          // end arrives mid-frame: held until the current or next bit mark finishes
          tx_end_held = 1'b1;
          r.accepted  = 1'b1;
        end
      end
    endcase
    r.ir_level  = tx_burst(tx_phase) & tx_carr_lvl;
    r.ready_res = (tx_phase == PH_IDLE) || (tx_phase == PH_WAIT);
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic any_bit();
    return 1'($urandom_range(1));
  endfunction

  function automatic void push_word(logic [1:0] f, logic b);
    in_item_t w;
    w.func      = f;
    w.bit_value = b;
    tx_word_q.push_back(w);
    words_queued++;
  endfunction

  function automatic void push_ticks(int n);
    for (int k = 0; k < n; k++) push_word(FUNC_TICK, any_bit());
  endfunction

  // mostly exact, sometimes a few ticks long, now and then one tick short
  function automatic int tick_slack();
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return -1;
    if (r < 4) return int'($urandom_range(1, 4));
    return 0;
  endfunction

  function automatic void queue_header(int extra);
    push_word(FUNC_START, any_bit());
    push_ticks(int'(tx_cfg.header_mark_us) + int'(tx_cfg.header_space_us) +
               int'(tx_cfg.bit_mark_us) + extra);
  endfunction

  function automatic void queue_bit(logic b, int extra);
    push_word(FUNC_BIT, b);
    push_ticks(int'(b ? tx_cfg.one_space_us : tx_cfg.zero_space_us) +
               int'(tx_cfg.bit_mark_us) + extra);
  endfunction

  function automatic void queue_trailer();
    push_ticks(int'(tx_cfg.trailer_gap_us) + int'(tx_cfg.trailer_mark_us) +
               int'(TRAILER_GAP2) + int'(TRAILER_MARK2));
  endfunction

  // well-formed frame with random bits; optionally the end lands mid last bit
  function automatic void queue_frame(int nbits, bit cut_short);
    logic        b;
    int          tail;
    int unsigned cut;
    queue_header(tick_slack());
    for (int i = 0; i < nbits; i++) begin
      b = any_bit();
      if (cut_short && i == nbits - 1) begin
        push_word(FUNC_BIT, b);
        tail = int'(b ? tx_cfg.one_space_us : tx_cfg.zero_space_us) + int'(tx_cfg.bit_mark_us);
        cut  = $urandom_range(tail - 1);
        push_ticks(int'(cut));
        push_word(FUNC_END, any_bit());
        push_ticks(tail - int'(cut) + tick_slack());
      end else begin
        queue_bit(b, tick_slack());
      end
    end
    if (!cut_short) push_word(FUNC_END, any_bit());
    if (tx_cfg.trailer_enable) queue_trailer();
    if ($urandom_range(5) == 0) push_word(FUNC_END, any_bit());
  endfunction

  // hold off until every queued word has been taken and answered
  task automatic settle();
    while (tx_word_q.size() != 0 || in_valid_i || tx_result_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_HEADER_MARK:  tx_cfg.header_mark_us  = val;
      REG_HEADER_SPACE: tx_cfg.header_space_us = val;
      REG_BIT_MARK:     tx_cfg.bit_mark_us     = val;
      REG_ZERO_SPACE:   tx_cfg.zero_space_us   = val;
      REG_ONE_SPACE:    tx_cfg.one_space_us    = val;
      REG_TRAILER_EN:   tx_cfg.trailer_enable  = val[0];
      REG_TRAILER_GAP:  tx_cfg.trailer_gap_us  = val;
      REG_TRAILER_MARK: tx_cfg.trailer_mark_us = val;
      default: ;
    endcase
  endtask

  task automatic load_timing(logic [15:0] hm, logic [15:0] hs, logic [15:0] bm,
                             logic [15:0] zs, logic [15:0] os, logic te,
                             logic [15:0] tg, logic [15:0] tm);
    write_reg(REG_HEADER_MARK, hm);
    write_reg(REG_HEADER_SPACE, hs);
    write_reg(REG_BIT_MARK, bm);
    write_reg(REG_ZERO_SPACE, zs);
    write_reg(REG_ONE_SPACE, os);
    write_reg(REG_TRAILER_EN, {15'd0, te});
    write_reg(REG_TRAILER_GAP, tg);
    write_reg(REG_TRAILER_MARK, tm);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) tx_result_q.push_back(tx_step(in_data_i));
      if (!in_valid_i || in_ready_o) begin
        if (tx_word_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= tx_word_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i or negedge rst_ni) begin : result_check
    out_item_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (tx_result_q.size() == 0) begin
          tx_mismatches++;
          if (tx_mismatches <= REPORT_MAX)
            $display("result %0d: nothing expected, got ir=%b ready=%b acc=%b", results_seen,
                     out_data_o.ir_level, out_data_o.ready_res, out_data_o.accepted);
        end else begin
          want = tx_result_q.pop_front();
          if (out_data_o !== want) begin
            tx_mismatches++;
            if (tx_mismatches <= REPORT_MAX)
              $display("result %0d: expected ir=%b ready=%b acc=%b, got ir=%b ready=%b acc=%b",
                       results_seen, want.ir_level, want.ready_res, want.accepted,
                       out_data_o.ir_level, out_data_o.ready_res, out_data_o.accepted);
          end
        end
        results_seen++;
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int unsigned set_start;
    tx_cfg = '{header_mark_us: 16'd3400, header_space_us: 16'd1700, bit_mark_us: 16'd450,
               zero_space_us: 16'd500, one_space_us: 16'd1200, trailer_enable: 1'b0,
               trailer_gap_us: 16'd45356, trailer_mark_us: 16'd10240};
    tx_phase    = PH_IDLE;
    tx_left     = '0;
    tx_end_held = 1'b0;
    tx_carr_cnt = '0;
    tx_carr_lvl = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset timings: stray words while idle leave it idle
    push_word(FUNC_BIT, 1'b1);
    push_word(FUNC_END, any_bit());
    push_ticks(4);

    // short frame, zero-length zero space skipped, unused lengths at full scale
    load_timing(16'd8, 16'd4, 16'd3, 16'd0, 16'd5, 1'b0, 16'hFFFF, 16'hFFFF);
    queue_header(0);
    queue_bit(1'b1, 0);
    queue_bit(1'b0, 0);
    push_word(FUNC_END, any_bit());

    load_timing(16'd30, 16'd0, 16'd1, 16'd0, 16'd3, 1'b0, 16'd0, 16'd1);
    push_word(FUNC_BIT, 1'b1);      // bit while idle
    push_word(FUNC_END, any_bit()); // end while idle
    push_word(FUNC_TICK, any_bit());
    push_word(FUNC_START, any_bit());
    push_word(FUNC_START, any_bit()); // start while busy
    push_word(FUNC_BIT, 1'b0);        // bit during header
    push_word(FUNC_END, any_bit());   // held
    push_word(FUNC_END, any_bit());   // second end while one is held
    push_ticks(31);
    queue_header(0);
    push_word(FUNC_TICK, any_bit());  // tick while waiting
    push_word(FUNC_BIT, 1'b0);
    push_word(FUNC_END, any_bit());   // end during the bit mark
    push_ticks(1);

    write_reg(REG_UNMAPPED_LO, 16'hFFFF);
    write_reg(REG_UNMAPPED_HI, 16'h5A5A);

    for (int s = 0; s < 8; s++) begin
      // trailer stays off here: its fixed tail runs thousands of ticks
      if (s == 0) begin
        load_timing(16'd1, 16'd0, 16'd1, 16'd0, 16'd0, 1'b0, 16'd0, 16'd1);
      end else begin
        load_timing(16'($urandom_range(1, 6)), 16'($urandom_range(3)),
                    16'($urandom_range(1, 4)), 16'($urandom_range(2)),
                    16'($urandom_range(5)), 1'b0,
                    16'($urandom_range(30)), 16'($urandom_range(1, 40)));
      end
      case (s % 4)
        0: begin
          sender_idle_pct = 71;
          recv_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 71;
        end
        2: begin
          sender_idle_pct = 22;
          recv_stall_pct  = 22;
        end
        default: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
      endcase
      set_start = words_queued;
      while (words_queued - set_start < WORDS_PER_SET) begin
        if ($urandom_range(99) < 15) push_word(2'($urandom_range(3)), any_bit());
        else queue_frame($urandom_range(1, 4), $urandom_range(4) == 0);
        if ($urandom_range(11) == 0) settle();
      end
    end

    // trailer last: timings rewritten while a frame waits for its next bit,
    // then through the skipped gap and long burst into the fixed second gap
    load_timing(16'd5, 16'd2, 16'd3, 16'd1, 16'd4, 1'b0, 16'd0, 16'd30);
    queue_header(0);
    write_reg(REG_ONE_SPACE, 16'd2);
    write_reg(REG_TRAILER_EN, 16'd1);
    queue_bit(1'b1, 0);
    push_word(FUNC_END, any_bit());
    push_word(FUNC_START, any_bit()); // start during trailer
    push_word(FUNC_END, any_bit());   // end during trailer
    push_ticks(int'(tx_cfg.trailer_gap_us) + int'(tx_cfg.trailer_mark_us) + 20);

    settle();
    if (tx_mismatches == 0 && tx_result_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/ipdt_pkg.sv
rtl/ipdt_cfg.sv
rtl/ipdt_front.sv
rtl/ipdt_fifo.sv
rtl/ipdt_back.sv
rtl/ir_pulse_distance_transmitter_top.sv
test/tb_top.sv
